### rtl/kat_pkg.sv
`default_nettype none

package kat_pkg;

	localparam int MAX_RESULTS = 16;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	localparam logic [7:0] DEFAULT_FIRST = 8'd15;
	localparam logic [7:0] DEFAULT_PERIOD = 8'd4;

	// register indexes
	localparam logic REG_FIRST_DELAY = 1'b0;
	localparam logic REG_REPEAT_PERIOD = 1'b1;

	// input function codes
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_DOWN = 2'd1;
	localparam logic [1:0] OP_UP = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// event kinds
	localparam logic [1:0] EV_DOWN = 2'd0;
	localparam logic [1:0] EV_UP = 2'd1;
	localparam logic [1:0] EV_REPEAT = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] key;
	} kat_item_t;

	typedef struct packed {
		logic [7:0]  key;
		logic [31:0] stamp;
		logic        rep;
	} kat_slot_t;

endpackage

`default_nettype wire

### rtl/kat_front.sv
`default_nettype none

module kat_front import kat_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic [1:0] s_tuser,
	output logic           item_valid,
	input  wire logic      item_ready,
	output kat_item_t      item
);

	kat_item_t  fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign s_tready = (cnt_q != 2'd2);
	// unused function code is dropped here
	assign push = s_tvalid && s_tready && (s_tuser != OP_UNUSED);
	assign pop = item_valid && item_ready;
	assign item_valid = (cnt_q != 2'd0);
	assign item = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{op: s_tuser, key: s_tdata};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/kat_back.sv
`default_nettype none

module kat_back import kat_pkg::*; #(
	parameter int SLOT_COUNT = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_ready,
	input  kat_item_t       item,
	input  wire logic [7:0] first_delay,
	input  wire logic [7:0] repeat_period,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,
	output logic [1:0]      m_tuser,
	output logic            m_tlast
);

	localparam int IDXW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN = 2'd3;

	kat_slot_t mem [SLOT_COUNT];

	logic [1:0]            state_q;
	logic [1:0]            op_q;
	logic [7:0]            key_q;
	logic [31:0]           time_q;
	logic [SLOT_COUNT-1:0] occ_q;
	logic [IDXW-1:0]       rd_idx_q;
	logic [CNT_W-1:0]      rep_cnt_q;
	logic                  pend_valid_q;
	logic [7:0]            pend_key_q;

	kat_slot_t             rd_s1;
	logic [IDXW-1:0]       idx_s1;
	logic                  valid_s1;

	logic                  out_valid_q;
	logic [7:0]            out_key_q;
	logic [1:0]            out_kind_q;
	logic                  out_last_q;

	logic [7:0]            delay_raw;
	logic [7:0]            delay;
	logic [31:0]           elapsed;
	logic                  hit;
	logic                  out_ok;
	logic                  go_s1;
	logic                  advance;
	logic                  push_pend;
	logic                  fin_push;
	logic                  fin_done;
	logic                  free_any;
	logic [IDXW-1:0]       free_idx;
	logic                  claim;
	logic                  mem_we;
	logic [IDXW-1:0]       wr_idx;
	kat_slot_t             wr_data;
	logic                  rd_en;

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!occ_q[i]) begin
				free_any = 1'b1;
				free_idx = IDXW'(i);
			end
		end
	end

	assign delay_raw = rd_s1.rep ? repeat_period : first_delay;
	assign delay = (delay_raw == 8'd0) ? 8'd1 : delay_raw;
	assign elapsed = time_q - rd_s1.stamp;
	assign hit = valid_s1 && (op_q == OP_TICK) && occ_q[idx_s1]
		&& (rep_cnt_q < CNT_W'(MAX_RESULTS)) && (elapsed >= {24'd0, delay});

	assign out_ok = !out_valid_q || m_tready;
	// a new repeat pushes the one held back, so that the last can be marked
	assign go_s1 = !hit || !pend_valid_q || out_ok;
	assign advance = !valid_s1 || go_s1;
	assign push_pend = hit && pend_valid_q && out_ok;

	assign fin_push = (state_q == ST_FIN) && out_ok && ((op_q != OP_TICK) || pend_valid_q);
	assign fin_done = (state_q == ST_FIN) && (out_ok || ((op_q == OP_TICK) && !pend_valid_q));

	assign item_ready = (state_q == ST_IDLE);
	assign claim = (state_q == ST_IDLE) && item_valid && (item.op == OP_DOWN) && free_any;

	always_comb begin
		mem_we = 1'b0;
		wr_idx = idx_s1;
		wr_data = '{key: rd_s1.key, stamp: rd_s1.stamp + {24'd0, delay}, rep: 1'b1};
		if (claim) begin
			mem_we = 1'b1;
			wr_idx = free_idx;
			wr_data = '{key: item.key, stamp: time_q, rep: 1'b0};
		end else if (hit && go_s1) begin
			mem_we = 1'b1;
		end
	end

	assign rd_en = ((state_q == ST_SCAN) && advance);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_s1 <= mem[rd_idx_q];
			idx_s1 <= rd_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_TICK;
			key_q <= 8'd0;
			time_q <= 32'd0;
			occ_q <= '0;
			rd_idx_q <= '0;
			rep_cnt_q <= '0;
			pend_valid_q <= 1'b0;
			pend_key_q <= 8'd0;
			valid_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						op_q <= item.op;
						key_q <= item.key;
						rd_idx_q <= '0;
						rep_cnt_q <= '0;
						if (item.op == OP_TICK) begin
							time_q <= time_q + 32'd1;
						end
						if (claim) begin
							occ_q[free_idx] <= (item.key != 8'd0);
						end
						state_q <= (item.op == OP_DOWN) ? ST_FIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (advance) begin
						valid_s1 <= 1'b1;
						if (rd_idx_q == IDXW'(SLOT_COUNT - 1)) begin
							state_q <= ST_DRAIN;
						end else begin
							rd_idx_q <= rd_idx_q + IDXW'(1);
						end
					end
				end
				ST_DRAIN: begin
					if (advance) begin
						valid_s1 <= 1'b0;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_push && (op_q == OP_TICK)) begin
						pend_valid_q <= 1'b0;
					end
					if (fin_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (hit && go_s1) begin
				pend_valid_q <= 1'b1;
				pend_key_q <= rd_s1.key;
				rep_cnt_q <= rep_cnt_q + CNT_W'(1);
			end
			if (valid_s1 && (op_q == OP_UP) && occ_q[idx_s1] && (rd_s1.key == key_q)) begin
				occ_q[idx_s1] <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_pend || fin_push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_pend) begin
			out_kind_q <= EV_REPEAT;
			out_key_q <= pend_key_q;
			out_last_q <= 1'b0;
		end else if (fin_push) begin
			out_last_q <= 1'b1;
			if (op_q == OP_TICK) begin
				out_kind_q <= EV_REPEAT;
				out_key_q <= pend_key_q;
			end else begin
				out_kind_q <= (op_q == OP_DOWN) ? EV_DOWN : EV_UP;
				out_key_q <= key_q;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_key_q;
	assign m_tuser = out_kind_q;
	assign m_tlast = out_last_q;

endmodule

`default_nettype wire

### rtl/key_autorepeat_table.sv
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata[7:0] key_code, tuser[1:0] func
// m_*       out  m_tvalid/m_tready  tdata[7:0] event_key, tuser[1:0] event_kind,
//                                   tlast last_of_run
// cfg_*     in   cfg_we             cfg_addr register index, cfg_wdata value
//
// Key-down goes from idle straight to the finish state. Key-up and tick scan the
// slot memory through its single registered read port, one slot a cycle unless stalled.
// A two-entry queue in front accepts items while the engine works.
// Output stalls hold the scan at the slot that has a repeat to send.
// arst_n clears the slot occupancy flags and time at once and sets the registers to their defaults.

module key_autorepeat_table import kat_pkg::*; #(
	parameter int SLOT_COUNT = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // key_code
	input  wire logic [1:0] s_tuser,   // func
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // event_key
	output logic [1:0]      m_tuser,   // event_kind
	output logic            m_tlast,
	input  wire logic       cfg_we,
	input  wire logic       cfg_addr,
	input  wire logic [7:0] cfg_wdata
);

	logic [7:0] first_delay_q;
	logic [7:0] repeat_period_q;
	logic       item_valid;
	logic       item_ready;
	kat_item_t  item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_delay_q <= DEFAULT_FIRST;
			repeat_period_q <= DEFAULT_PERIOD;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_FIRST_DELAY: first_delay_q <= cfg_wdata;
				REG_REPEAT_PERIOD: repeat_period_q <= cfg_wdata;
				default: first_delay_q <= first_delay_q;
			endcase
		end
	end

	kat_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	kat_back #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.item          (item),
		.first_delay   (first_delay_q),
		.repeat_period (repeat_period_q),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast)
	);

	a_echo_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == EV_DOWN || m_tuser == EV_UP) |-> m_tlast)
		else $error("down/up event without tlast");

	a_queue_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(item))
		else $error("queue head changed while stalled");

	a_no_unused: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid |-> item.op != OP_UNUSED)
		else $error("unused function code reached engine");

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import kat_pkg::*;

	localparam int SLOTS = 16;
	localparam int SETTLE_CYCLES = 4 * (SLOTS + 4);
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 65;
	localparam int POOL_KEYS = 6;

	localparam int RDY_ALWAYS = 0;
	localparam int RDY_RANDOM = 1;
	localparam int RDY_PERIODIC = 2;
	localparam int RDY_WINDOWS = 3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] key;
		logic       last;
	} key_event_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] key;
		logic       typed;
		logic       echo;
		logic [1:0] kind;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic [1:0] s_tuser;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;
	logic       cfg_we;
	logic       cfg_addr;
	logic [7:0] cfg_wdata;

	key_autorepeat_table #(.SLOT_COUNT(SLOTS)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // key_code
		.s_tuser  (s_tuser),   // func
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // event_key
		.m_tuser  (m_tuser),   // event_kind
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mirror of the key table
	logic [31:0] now_ticks;
	logic [7:0]  held_key [SLOTS];
	logic [31:0] held_stamp [SLOTS];
	logic        held_rep [SLOTS];
	logic [7:0]  first_delay_r;
	logic [7:0]  repeat_period_r;

	key_event_t pending_events[$];
	key_event_t new_events[$];

	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	bit gaps_on = 1'b1;
	int ready_mode = RDY_ALWAYS;
	int ready_cycle = 0;
	int hold_cnt = 0;
	bit hold_level = 1'b1;

	stim_row_t dir_rows [25] = '{
		'{OP_TICK,   8'hA5, 1'b0, 1'b0, EV_DOWN},
		'{OP_UNUSED, 8'hFF, 1'b1, 1'b0, EV_DOWN},
		'{OP_DOWN,   8'hFF, 1'b1, 1'b1, EV_DOWN},
		'{OP_DOWN,   8'h00, 1'b1, 1'b1, EV_DOWN},
		'{OP_UP,     8'h00, 1'b1, 1'b1, EV_UP},
		'{OP_DOWN,   8'h01, 1'b1, 1'b1, EV_DOWN},
		'{OP_DOWN,   8'h02, 1'b1, 1'b1, EV_DOWN},
		'{OP_DOWN,   8'h04, 1'b1, 1'b1, EV_DOWN},
		'{OP_DOWN,   8'h08, 1'b1, 1'b1, EV_DOWN},
		'{OP_DOWN,   8'h10, 1'b1, 1'b1, EV_DOWN},
		'{OP_DOWN,   8'h20, 1'b1, 1'b1, EV_DOWN},
		'{OP_DOWN,   8'h40, 1'b1, 1'b1, EV_DOWN},
		'{OP_DOWN,   8'h80, 1'b1, 1'b1, EV_DOWN},
		'{OP_DOWN,   8'h03, 1'b1, 1'b1, EV_DOWN},
		'{OP_DOWN,   8'h0C, 1'b1, 1'b1, EV_DOWN},
		'{OP_DOWN,   8'h30, 1'b1, 1'b1, EV_DOWN},
		'{OP_DOWN,   8'hC0, 1'b1, 1'b1, EV_DOWN},
		'{OP_DOWN,   8'h7E, 1'b1, 1'b1, EV_DOWN},
		'{OP_DOWN,   8'h81, 1'b1, 1'b1, EV_DOWN},
		'{OP_DOWN,   8'h5A, 1'b1, 1'b1, EV_DOWN},
		'{OP_DOWN,   8'hAA, 1'b1, 1'b1, EV_DOWN},   // table full
		'{OP_UP,     8'hFF, 1'b1, 1'b1, EV_UP},
		'{OP_DOWN,   8'h55, 1'b1, 1'b1, EV_DOWN},
		'{OP_UP,     8'h01, 1'b1, 1'b1, EV_UP},
		'{OP_TICK,   8'h00, 1'b0, 1'b0, EV_DOWN}
	};

	logic [7:0] phase_first [PHASES] = '{8'd3, 8'd255, 8'd1, 8'd0, 8'd40, 8'd0};
	logic [7:0] phase_period [PHASES] = '{8'd2, 8'd255, 8'd1, 8'd0, 8'd1, 8'd0};

	task automatic advance_keyboard(input logic [1:0] op, input logic [7:0] key);
		logic [31:0] dly;
		logic [31:0] gone;
		bit claimed;
		new_events = {};
		case (op)
			OP_DOWN: begin
				claimed = 1'b0;
				for (int i = 0; i < SLOTS; i++) begin
					if (!claimed && held_key[i] == 8'd0) begin
						held_key[i] = key;
						held_stamp[i] = now_ticks;
						held_rep[i] = 1'b0;
						claimed = 1'b1;
					end
				end
				new_events.push_back('{EV_DOWN, key, 1'b1});
			end
			OP_UP: begin
				for (int i = 0; i < SLOTS; i++)
					if (held_key[i] == key)
						held_key[i] = 8'd0;
				new_events.push_back('{EV_UP, key, 1'b1});
			end
			OP_TICK: begin
				now_ticks = now_ticks + 32'd1;
				for (int i = 0; i < SLOTS; i++) begin
					if (held_key[i] != 8'd0 && new_events.size() < MAX_RESULTS) begin
						dly = held_rep[i] ? {24'd0, repeat_period_r} : {24'd0, first_delay_r};
						if (dly == 32'd0)
							dly = 32'd1;
						gone = now_ticks - held_stamp[i];
						if (gone >= dly) begin
							held_stamp[i] = held_stamp[i] + dly;
							held_rep[i] = 1'b1;
							new_events.push_back('{EV_REPEAT, held_key[i], 1'b0});
						end
					end
				end
				if (new_events.size() > 0)
					new_events[new_events.size() - 1].last = 1'b1;
			end
			default: ;
		endcase
	endtask

	task automatic write_reg(input logic addr, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= val;
		@(posedge clk);
		if (addr == REG_FIRST_DELAY)
			first_delay_r = val;
		else
			repeat_period_r = val;
		@(negedge clk);
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_item(input logic [1:0] op, input logic [7:0] key, input logic typed,
			input logic echo, input logic [1:0] kind);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (gaps_on) begin
				gap = $urandom_range(0, 8);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= key;
		do @(posedge clk); while (!s_tready);
		advance_keyboard(op, key);
		if (typed) begin
			if (echo)
				pending_events.push_back('{kind, key, 1'b1});
		end else begin
			foreach (new_events[j])
				pending_events.push_back(new_events[j]);
		end
		@(negedge clk);
	endtask

	// let the block go quiet, quiet ticks included
	task automatic drain;
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_events.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endtask

	always @(negedge clk) begin
		ready_cycle++;
		case (ready_mode)
			RDY_ALWAYS: m_tready <= 1'b1;
			RDY_RANDOM: m_tready <= ($urandom_range(0, 99) < 65);
			RDY_PERIODIC: m_tready <= ((ready_cycle % 7) < 4);
			RDY_WINDOWS: begin
				if (hold_cnt == 0) begin
					hold_level = !hold_level;
					hold_cnt = $urandom_range(1, 10);
				end
				hold_cnt--;
				m_tready <= hold_level;
			end
			default: m_tready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		key_event_t want;
		key_event_t got;
		if (!arst_n) begin
			idle_cycles = 0;
		end else begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (m_tvalid && m_tready) begin
				got = '{m_tuser, m_tdata, m_tlast};
				if (pending_events.size() == 0) begin
					flag_error($sformatf("unexpected transfer: kind %0d key %02h last %0b",
						got.kind, got.key, got.last));
				end else begin
					want = pending_events.pop_front();
					if (want != got)
						flag_error($sformatf(
							"mismatch: kind %0d/%0d key %02h/%02h last %0b/%0b (exp/act)",
							want.kind, got.kind, want.key, got.key, want.last, got.last));
				end
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] key_pool [POOL_KEYS];
		logic [1:0] op;
		logic [7:0] key;
		logic [7:0] fd;
		logic [7:0] rp;
		int counted;
		int r;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		s_tuser = OP_TICK;
		cfg_we = 1'b0;
		cfg_addr = REG_FIRST_DELAY;
		cfg_wdata = 8'd0;
		now_ticks = 32'd0;
		for (int i = 0; i < SLOTS; i++) begin
			held_key[i] = 8'd0;
			held_stamp[i] = 32'd0;
			held_rep[i] = 1'b0;
		end
		first_delay_r = DEFAULT_FIRST;
		repeat_period_r = DEFAULT_PERIOD;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		ready_mode = RDY_RANDOM;
		foreach (dir_rows[i])
			send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typed,
				dir_rows[i].echo, dir_rows[i].kind);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			fd = phase_first[ph];
			rp = phase_period[ph];
			if (ph == PHASES - 1) begin
				fd = 8'($urandom_range(1, 255));
				rp = 8'($urandom_range(1, 255));
			end
			write_reg(REG_FIRST_DELAY, fd);
			write_reg(REG_REPEAT_PERIOD, rp);
			cfg_we <= 1'b0;
			ready_mode = ph % 4;
			gaps_on = (ph != 1);
			foreach (key_pool[k])
				key_pool[k] = 8'($urandom_range(1, 255));
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
				if (r < 62) begin
					op = OP_TICK;
					key = 8'($urandom_range(0, 255));
				end else if (r < 78) begin
					op = OP_DOWN;
				end else if (r < 93) begin
					op = OP_UP;
				end else if (r < 97) begin
					op = $urandom_range(0, 1) ? OP_DOWN : OP_UP;
					key = 8'($urandom_range(0, 255));
				end else begin
					op = OP_UNUSED;
					key = 8'($urandom_range(0, 255));
				end
				if (op != OP_UNUSED)
					counted++;
				send_item(op, key, 1'b0, 1'b0, EV_DOWN);
			end
			drain();
		end

		if (errors == 0 && pending_events.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### key_autorepeat_table.f
rtl/kat_pkg.sv
rtl/kat_front.sv
rtl/kat_back.sv
rtl/key_autorepeat_table.sv
verif/tb_top.sv
